@@ rtl/ptpd_pkg.sv @@
// Shared types and constants for the point-to-polyline distance block.
`timescale 1ns / 1ps

package ptpd_pkg;

    localparam int FIELD_W         = 31;   // coordinate field width on the stream
    localparam int COORD_BITS_DEF  = 31;   // default coordinate width in use
    localparam int MUL_W           = 33;   // shared multiplier operand width
    localparam int PROD_W          = 2 * MUL_W;
    localparam int SQ_W            = 64;   // squared distances and sums
    localparam int WIDE_W          = 2 * SQ_W;
    localparam int DIST_W          = 32;
    localparam int IN_TDATA_W      = ((4 * FIELD_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W     = ((DIST_W + 7) / 8) * 8;
    localparam int MUL_STEPS       = 8;    // products per segment before n1 is squared
    localparam int STEP_W          = $clog2(MUL_STEPS + 1);
    localparam int SQ_STEPS        = 3;    // partial products of n1 squared
    localparam int DIV_ITERS       = 64;
    localparam int ROOT_ITERS      = 32;
    localparam int ITER_CNT_W      = $clog2(DIV_ITERS + 1);

    // Command from the sequencer to the iterative divide / root unit.
    typedef struct packed {
        logic start;
        logic sqrt_mode;
    } iter_cmd_t;

endpackage

@@ rtl/ptpd_mul.sv @@
// Shared signed multiplier with a registered product.
`timescale 1ns / 1ps

module ptpd_mul (
    input  logic                                  clk,
    input  logic signed [ptpd_pkg::MUL_W-1:0]     op_a,
    input  logic signed [ptpd_pkg::MUL_W-1:0]     op_b,
    output logic signed [ptpd_pkg::PROD_W-1:0]    prod
);
    import ptpd_pkg::*;

    logic signed [PROD_W-1:0] prod_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= PROD_W'(op_a) * PROD_W'(op_b);
    end

    assign prod = prod_reg;

endmodule

@@ rtl/ptpd_divsqrt.sv @@
// Iterative restoring unit: 128/64 divide or 64-bit integer square root.
`timescale 1ns / 1ps

module ptpd_divsqrt (
    input  logic                           clk,
    input  logic                           rst_n,
    input  ptpd_pkg::iter_cmd_t            cmd,
    input  logic [ptpd_pkg::SQ_W-1:0]      num_hi,
    input  logic [ptpd_pkg::SQ_W-1:0]      num_lo,
    input  logic [ptpd_pkg::SQ_W-1:0]      divisor,
    output logic                           done,
    output logic [ptpd_pkg::SQ_W-1:0]      result
);
    import ptpd_pkg::*;

    localparam int CAND_W = SQ_W + 2;

    logic [ITER_CNT_W-1:0] cnt_reg, cnt_next;
    logic                  mode_reg, mode_next;
    logic                  done_reg, done_next;
    logic [SQ_W-1:0]       rem_reg, rem_next;
    logic [SQ_W-1:0]       sh_reg, sh_next;
    logic [SQ_W-1:0]       q_reg, q_next;
    logic [SQ_W-1:0]       div_reg, div_next;

    logic [CAND_W-1:0]     cand;
    logic [CAND_W-1:0]     trial;
    logic [CAND_W:0]       diff;
    logic                  fits;

    always_comb
    begin
        // Bring down one dividend bit, or one bit pair for the root.
        if (mode_reg)
        begin
            cand  = {rem_reg, sh_reg[SQ_W-1 -: 2]};
            trial = {q_reg, 2'b01};
        end
        else
        begin
            cand  = {1'b0, rem_reg, sh_reg[SQ_W-1]};
            trial = {2'b00, div_reg};
        end
        diff = {1'b0, cand} - {1'b0, trial};
        fits = ~diff[CAND_W];

        cnt_next  = cnt_reg;
        mode_next = mode_reg;
        done_next = 1'b0;
        rem_next  = rem_reg;
        sh_next   = sh_reg;
        q_next    = q_reg;
        div_next  = div_reg;

        if (cmd.start)
        begin
            mode_next = cmd.sqrt_mode;
            rem_next  = cmd.sqrt_mode ? '0 : num_hi;
            sh_next   = num_lo;
            q_next    = '0;
            div_next  = divisor;
            cnt_next  = cmd.sqrt_mode ? ITER_CNT_W'(ROOT_ITERS) : ITER_CNT_W'(DIV_ITERS);
        end
        else if (cnt_reg != '0)
        begin
            rem_next  = fits ? diff[SQ_W-1:0] : cand[SQ_W-1:0];
            q_next    = {q_reg[SQ_W-2:0], fits};
            sh_next   = mode_reg ? {sh_reg[SQ_W-3:0], 2'b00} : {sh_reg[SQ_W-2:0], 1'b0};
            cnt_next  = cnt_reg - 1'b1;
            done_next = (cnt_reg == ITER_CNT_W'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            mode_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            mode_reg <= mode_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        sh_reg  <= sh_next;
        q_reg   <= q_next;
        div_reg <= div_next;
    end

    assign done   = done_reg;
    assign result = q_reg;

endmodule

@@ rtl/point_to_polyline_distance.sv @@
// Point-to-polyline distance: top level with sequencer, registers and output stage.
// A request carries one polyline vertex and the query point, which is taken from a
// line's first vertex only. Each later vertex closes a segment; its work ends with
// the products when the projection falls on an end point or the segment is
// degenerate. When it falls inside, three more products (n1 squared) and a 64-step
// divide follow. The last vertex after a segment adds the 32-step root and the
// output load. All products go through one registered 33x33 multiplier and the
// divide and root share one iterative subtract-and-compare unit, so the block takes
// one request at a time; a finished result waits in an output register while the
// next request is accepted.
`timescale 1ns / 1ps

module point_to_polyline_distance #(
    parameter int COORD_BITS = ptpd_pkg::COORD_BITS_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    // query_x[30:0], query_y[61:31], vertex_x[92:62], vertex_y[123:93], zero pad
    input  logic [ptpd_pkg::IN_TDATA_W-1:0]       s_axis_tdata,
    input  logic                                  s_axis_tlast,
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    // distance[31:0]
    output logic [ptpd_pkg::OUT_TDATA_W-1:0]      m_axis_tdata,
    // no_segment[0]
    output logic [0:0]                            m_axis_tuser
);
    import ptpd_pkg::*;

    localparam int DIFF_W = COORD_BITS + 1;

    typedef enum logic [10:0] {
        S_IDLE   = 11'b000_0000_0001,
        S_DIFF   = 11'b000_0000_0010,
        S_MUL    = 11'b000_0000_0100,
        S_CHK    = 11'b000_0000_1000,
        S_SQ     = 11'b000_0001_0000,
        S_DIVGO  = 11'b000_0010_0000,
        S_DIVW   = 11'b000_0100_0000,
        S_MIN    = 11'b000_1000_0000,
        S_ROOTGO = 11'b001_0000_0000,
        S_ROOTW  = 11'b010_0000_0000,
        S_OUT    = 11'b100_0000_0000
    } state_t;

    state_t                    state_reg, state_next;
    logic [STEP_W-1:0]         step_reg, step_next;
    logic                      have_prev_reg, have_prev_next;
    logic                      last_reg, last_next;
    logic [SQ_W-1:0]           min_reg, min_next;
    logic                      out_valid_reg, out_valid_next;

    logic signed [COORD_BITS-1:0] hqx_reg, hqx_next, hqy_reg, hqy_next;
    logic signed [COORD_BITS-1:0] prvx_reg, prvx_next, prvy_reg, prvy_next;
    logic signed [COORD_BITS-1:0] curx_reg, curx_next, cury_reg, cury_next;
    logic signed [DIFF_W-1:0]  apx_reg, apx_next, apy_reg, apy_next;
    logic signed [DIFF_W-1:0]  bpx_reg, bpx_next, bpy_reg, bpy_next;
    logic signed [DIFF_W-1:0]  abx_reg, abx_next, aby_reg, aby_next;
    logic [SQ_W-1:0]           ap2_reg, ap2_next, bp2_reg, bp2_next;
    logic [SQ_W-1:0]           n2_reg, n2_next;
    logic signed [SQ_W-1:0]    n1_reg, n1_next;
    logic [WIDE_W-1:0]         acc_reg, acc_next;
    logic [SQ_W-1:0]           dseg_reg, dseg_next;
    logic [DIST_W-1:0]         out_dist_reg, out_dist_next;
    logic                      out_noseg_reg, out_noseg_next;

    logic signed [COORD_BITS-1:0] in_qx, in_qy, in_vx, in_vy;
    logic signed [MUL_W-1:0]   mul_a, mul_b;
    logic signed [PROD_W-1:0]  mul_p;
    logic [SQ_W-1:0]           prod64;
    logic [MUL_W-1:0]          n1_lo, n1_hi;
    iter_cmd_t                 iter_cmd;
    logic                      iter_done;
    logic [SQ_W-1:0]           iter_result;
    logic                      in_fire;
    logic                      out_load;

    assign in_qx = $signed(s_axis_tdata[0 +: COORD_BITS]);
    assign in_qy = $signed(s_axis_tdata[FIELD_W +: COORD_BITS]);
    assign in_vx = $signed(s_axis_tdata[2 * FIELD_W +: COORD_BITS]);
    assign in_vy = $signed(s_axis_tdata[3 * FIELD_W +: COORD_BITS]);

    assign s_axis_tready = (state_reg == S_IDLE);
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign prod64        = mul_p[SQ_W-1:0];
    assign n1_lo         = {1'b0, n1_reg[SQ_W/2-1:0]};
    assign n1_hi         = {1'b0, n1_reg[SQ_W-1:SQ_W/2]};

    // Operand select for the shared multiplier.
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        if (state_reg == S_MUL)
        begin
            case (step_reg)
                STEP_W'(0): begin mul_a = MUL_W'(apx_reg); mul_b = MUL_W'(apx_reg); end
                STEP_W'(1): begin mul_a = MUL_W'(apy_reg); mul_b = MUL_W'(apy_reg); end
                STEP_W'(2): begin mul_a = MUL_W'(bpx_reg); mul_b = MUL_W'(bpx_reg); end
                STEP_W'(3): begin mul_a = MUL_W'(bpy_reg); mul_b = MUL_W'(bpy_reg); end
                STEP_W'(4): begin mul_a = MUL_W'(abx_reg); mul_b = MUL_W'(abx_reg); end
                STEP_W'(5): begin mul_a = MUL_W'(aby_reg); mul_b = MUL_W'(aby_reg); end
                STEP_W'(6): begin mul_a = MUL_W'(apx_reg); mul_b = MUL_W'(abx_reg); end
                STEP_W'(7): begin mul_a = MUL_W'(apy_reg); mul_b = MUL_W'(aby_reg); end
                default:    begin mul_a = '0; mul_b = '0; end
            endcase
        end
        else if (state_reg == S_SQ)
        begin
            case (step_reg)
                STEP_W'(0): begin mul_a = $signed(n1_lo); mul_b = $signed(n1_lo); end
                STEP_W'(1): begin mul_a = $signed(n1_lo); mul_b = $signed(n1_hi); end
                STEP_W'(2): begin mul_a = $signed(n1_hi); mul_b = $signed(n1_hi); end
                default:    begin mul_a = '0; mul_b = '0; end
            endcase
        end
    end

    ptpd_mul u_mul (
        .clk  (clk),
        .op_a (mul_a),
        .op_b (mul_b),
        .prod (mul_p)
    );

    ptpd_divsqrt u_divsqrt (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (iter_cmd),
        .num_hi  ((state_reg == S_ROOTGO) ? '0 : acc_reg[WIDE_W-1:SQ_W]),
        .num_lo  ((state_reg == S_ROOTGO) ? min_reg : acc_reg[SQ_W-1:0]),
        .divisor (n2_reg),
        .done    (iter_done),
        .result  (iter_result)
    );

    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        have_prev_next = have_prev_reg;
        last_next      = last_reg;
        min_next       = min_reg;
        hqx_next       = hqx_reg;
        hqy_next       = hqy_reg;
        prvx_next      = prvx_reg;
        prvy_next      = prvy_reg;
        curx_next      = curx_reg;
        cury_next      = cury_reg;
        apx_next       = apx_reg;
        apy_next       = apy_reg;
        bpx_next       = bpx_reg;
        bpy_next       = bpy_reg;
        abx_next       = abx_reg;
        aby_next       = aby_reg;
        ap2_next       = ap2_reg;
        bp2_next       = bp2_reg;
        n2_next        = n2_reg;
        n1_next        = n1_reg;
        acc_next       = acc_reg;
        dseg_next      = dseg_reg;
        out_dist_next  = out_dist_reg;
        out_noseg_next = out_noseg_reg;
        iter_cmd       = '0;
        out_load       = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    last_next = s_axis_tlast;
                    curx_next = in_vx;
                    cury_next = in_vy;
                    if (!have_prev_reg)
                    begin
                        // Open a line: sample the query point.
                        hqx_next  = in_qx;
                        hqy_next  = in_qy;
                        prvx_next = in_vx;
                        prvy_next = in_vy;
                        min_next  = '1;
                        if (s_axis_tlast)
                        begin
                            dseg_next  = '1;
                            state_next = S_OUT;
                        end
                        else
                        begin
                            have_prev_next = 1'b1;
                        end
                    end
                    else
                    begin
                        state_next = S_DIFF;
                    end
                end
            end
            S_DIFF:
            begin
                apx_next   = DIFF_W'(hqx_reg) - DIFF_W'(prvx_reg);
                apy_next   = DIFF_W'(hqy_reg) - DIFF_W'(prvy_reg);
                bpx_next   = DIFF_W'(hqx_reg) - DIFF_W'(curx_reg);
                bpy_next   = DIFF_W'(hqy_reg) - DIFF_W'(cury_reg);
                abx_next   = DIFF_W'(curx_reg) - DIFF_W'(prvx_reg);
                aby_next   = DIFF_W'(cury_reg) - DIFF_W'(prvy_reg);
                step_next  = '0;
                state_next = S_MUL;
            end
            S_MUL:
            begin
                // The product issued in the previous step arrives here from the multiplier register.
                case (step_reg)
                    STEP_W'(1): ap2_next = prod64;
                    STEP_W'(2): ap2_next = ap2_reg + prod64;
                    STEP_W'(3): bp2_next = prod64;
                    STEP_W'(4): bp2_next = bp2_reg + prod64;
                    STEP_W'(5): n2_next  = prod64;
                    STEP_W'(6): n2_next  = n2_reg + prod64;
                    STEP_W'(7): n1_next  = $signed(prod64);
                    STEP_W'(8): n1_next  = n1_reg + $signed(prod64);
                    default:    ;
                endcase
                if (step_reg == STEP_W'(MUL_STEPS))
                begin
                    step_next  = '0;
                    state_next = S_CHK;
                end
                else
                begin
                    step_next = step_reg + 1'b1;
                end
            end
            S_CHK:
            begin
                if (n2_reg == '0 || n1_reg <= 0)
                begin
                    dseg_next  = ap2_reg;
                    state_next = S_MIN;
                end
                else if ($unsigned(n1_reg) >= n2_reg)
                begin
                    dseg_next  = bp2_reg;
                    state_next = S_MIN;
                end
                else
                begin
                    step_next  = '0;
                    state_next = S_SQ;
                end
            end
            S_SQ:
            begin
                // n1^2 = lo*lo + 2*lo*hi*2^32 + hi*hi*2^64
                case (step_reg)
                    STEP_W'(1): acc_next = WIDE_W'(prod64);
                    STEP_W'(2): acc_next = acc_reg + WIDE_W'({prod64, 1'b0, 32'd0});
                    STEP_W'(3): acc_next = acc_reg + {prod64, 64'd0};
                    default:    ;
                endcase
                if (step_reg == STEP_W'(SQ_STEPS))
                begin
                    step_next  = '0;
                    state_next = S_DIVGO;
                end
                else
                begin
                    step_next = step_reg + 1'b1;
                end
            end
            S_DIVGO:
            begin
                iter_cmd.start     = 1'b1;
                iter_cmd.sqrt_mode = 1'b0;
                state_next         = S_DIVW;
            end
            S_DIVW:
            begin
                if (iter_done)
                begin
                    dseg_next  = (iter_result > ap2_reg) ? '0 : ap2_reg - iter_result;
                    state_next = S_MIN;
                end
            end
            S_MIN:
            begin
                if (dseg_reg < min_reg)
                begin
                    min_next = dseg_reg;
                end
                prvx_next  = curx_reg;
                prvy_next  = cury_reg;
                state_next = last_reg ? S_ROOTGO : S_IDLE;
            end
            S_ROOTGO:
            begin
                iter_cmd.start     = 1'b1;
                iter_cmd.sqrt_mode = 1'b1;
                state_next         = S_ROOTW;
            end
            S_ROOTW:
            begin
                if (iter_done)
                begin
                    dseg_next  = iter_result;
                    min_next   = '1;
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                // Hold until the output register is free; an open line means a segment was seen.
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_load       = 1'b1;
                    out_dist_next  = dseg_reg[DIST_W-1:0];
                    out_noseg_next = !have_prev_reg;
                    have_prev_next = 1'b0;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            step_reg      <= '0;
            have_prev_reg <= 1'b0;
            min_reg       <= '1;
            out_valid_reg <= 1'b0;
            hqx_reg       <= '0;
            hqy_reg       <= '0;
            prvx_reg      <= '0;
            prvy_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            have_prev_reg <= have_prev_next;
            min_reg       <= min_next;
            out_valid_reg <= out_valid_next;
            hqx_reg       <= hqx_next;
            hqy_reg       <= hqy_next;
            prvx_reg      <= prvx_next;
            prvy_reg      <= prvy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        last_reg      <= last_next;
        curx_reg      <= curx_next;
        cury_reg      <= cury_next;
        apx_reg       <= apx_next;
        apy_reg       <= apy_next;
        bpx_reg       <= bpx_next;
        bpy_reg       <= bpy_next;
        abx_reg       <= abx_next;
        aby_reg       <= aby_next;
        ap2_reg       <= ap2_next;
        bp2_reg       <= bp2_next;
        n2_reg        <= n2_next;
        n1_reg        <= n1_next;
        acc_reg       <= acc_next;
        dseg_reg      <= dseg_next;
        out_dist_reg  <= out_dist_next;
        out_noseg_reg <= out_noseg_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = OUT_TDATA_W'(out_dist_reg);
    assign m_axis_tuser  = out_noseg_reg;

`ifndef SYNTHESIS
    a_done_when_waiting: assert property (@(posedge clk) disable iff (!rst_n)
        iter_done |-> (state_reg == S_DIVW || state_reg == S_ROOTW))
        else $error("iterative unit finished outside a wait state");

    a_seg_le_ap2: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MIN) |-> (dseg_reg <= ap2_reg))
        else $error("segment distance exceeds distance to its start vertex");

    a_rearm_after_result: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> (!have_prev_reg && min_reg == '1))
        else $error("line not rearmed after its result");
`endif

endmodule
